@@ sv/annexb_pkg.sv @@
`timescale 1ns / 1ps
package annexb_pkg;

  // Command queue geometry
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  // Byte values that make up start codes and terminators
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;

  // Widest burst one input byte can cause: three held bytes plus the final byte
  localparam int BurstMax = 4;
  localparam int BurstIdxW = $clog2(BurstMax);

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        unit_first;
    logic        unit_last;
    logic [15:0] unit_number;
  } out_item_t;

  // One burst of results produced by a single input byte
  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [BurstIdxW-1:0]     last_idx;
    logic                     first;
    logic                     last;
    logic [15:0]              unit_number;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic is_term(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return (a == ByteZero) && (b == ByteZero) && ((c == ByteZero) || (c == ByteOne));
  endfunction

  function automatic logic is_start(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return (a == ByteZero) && (b == ByteZero) && (c == ByteOne);
  endfunction

endpackage

@@ sv/annexb_front.sv @@
`timescale 1ns / 1ps
module annexb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  annexb_pkg::in_item_t in_item,
  output logic                wr_en,
  output annexb_pkg::cmd_t    cmd
);
  import annexb_pkg::*;

  logic [2:0][7:0] la_r, la_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic            inside_r, inside_nxt;
  logic            first_r, first_nxt;
  logic [15:0]     cnt_r, cnt_nxt;

  logic [7:0]      b;
  logic            fin;
  logic [2:0][7:0] shifted;
  logic            emit;
  logic [15:0]     num_emit;

  assign b        = in_item.stream_byte;
  assign fin      = in_item.stream_end;
  assign shifted  = {b, la_r[2], la_r[1]};
  assign num_emit = cnt_r + {15'd0, first_r};

  // Framing decision for one accepted byte
  always_comb begin
    la_nxt     = la_r;
    fill_nxt   = fill_r;
    inside_nxt = inside_r;
    first_nxt  = first_r;
    cnt_nxt    = cnt_r;
    emit       = 1'b0;
    cmd        = '0;
    cmd.unit_number = num_emit;
    cmd.first  = first_r;

    if (!inside_r) begin
      // searching: slide the window and look for 00 00 01
      la_nxt   = shifted;
      fill_nxt = (fill_r == 2'd3) ? 2'd3 : fill_r + 2'd1;
      if (fill_nxt == 2'd3 && is_start(shifted[0], shifted[1], shifted[2])) begin
        inside_nxt = 1'b1;
        first_nxt  = 1'b1;
        fill_nxt   = 2'd0;
      end
      if (fin) begin
        la_nxt     = '0;
        fill_nxt   = 2'd0;
        inside_nxt = 1'b0;
        first_nxt  = 1'b0;
      end
    end else if (fin) begin
      // end of stream: flush held bytes, final byte closes the unit
      emit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        cmd.bytes[i] = (2'(i) < fill_r) ? la_r[i] : b;
      end
      cmd.bytes[3] = b;
      cmd.last_idx = fill_r;
      cmd.last     = 1'b1;
      cnt_nxt      = num_emit;
      la_nxt       = '0;
      fill_nxt     = 2'd0;
      inside_nxt   = 1'b0;
      first_nxt    = 1'b0;
    end else if (fill_r != 2'd3) begin
      // filling lookahead after a start code
      la_nxt[fill_r] = b;
      fill_nxt       = fill_r + 2'd1;
      if (fill_nxt == 2'd3 && is_term(la_nxt[0], la_nxt[1], la_nxt[2])) begin
        inside_nxt = 1'b0;
        first_nxt  = 1'b0;
        if (is_start(la_nxt[0], la_nxt[1], la_nxt[2])) begin
          inside_nxt = 1'b1;
          first_nxt  = 1'b1;
          fill_nxt   = 2'd0;
        end
      end
    end else begin
      // steady state: release the oldest byte, check for terminator
      emit         = 1'b1;
      cmd.bytes[0] = la_r[0];
      cmd.last_idx = '0;
      cmd.last     = is_term(la_r[1], la_r[2], b);
      cnt_nxt      = num_emit;
      first_nxt    = 1'b0;
      la_nxt       = shifted;
      if (cmd.last) begin
        inside_nxt = 1'b0;
        fill_nxt   = 2'd3;
        if (is_start(shifted[0], shifted[1], shifted[2])) begin
          inside_nxt = 1'b1;
          first_nxt  = 1'b1;
          fill_nxt   = 2'd0;
        end
      end
    end
  end

  assign wr_en = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r     <= '0;
      fill_r   <= 2'd0;
      inside_r <= 1'b0;
      first_r  <= 1'b0;
      cnt_r    <= 16'd0;
    end else if (accept) begin
      la_r     <= la_nxt;
      fill_r   <= fill_nxt;
      inside_r <= inside_nxt;
      first_r  <= first_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/annexb_cmd_fifo.sv @@
`timescale 1ns / 1ps
module annexb_cmd_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  annexb_pkg::cmd_t       wr_cmd,
  input  logic                   rd_en,
  output annexb_pkg::cmd_t       rd_cmd,
  output annexb_pkg::fifo_stat_t stat
);
  import annexb_pkg::*;

  cmd_t                mem_r [FifoDepth];
  logic [FifoPtrW-1:0] wp_r, wp_nxt;
  logic [FifoPtrW-1:0] rp_r, rp_nxt;
  logic [FifoCntW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FifoCntW'(FifoDepth));
  assign stat.empty = (cnt_r == '0);
  assign rd_cmd     = mem_r[rp_r];

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == FifoPtrW'(FifoDepth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == FifoPtrW'(FifoDepth - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_cmd;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FifoCntW'(FifoDepth))
    else $error("command queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !wr_en || rd_en)
    else $error("command written into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !rd_en)
    else $error("command read from empty queue");

endmodule

@@ sv/annexb_back.sv @@
`timescale 1ns / 1ps
module annexb_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  annexb_pkg::cmd_t       cmd,
  input  annexb_pkg::fifo_stat_t stat,
  output logic                   rd_en,
  input  logic                   out_pop,
  output logic                   out_empty,
  output annexb_pkg::out_item_t  out_item
);
  import annexb_pkg::*;

  logic [BurstIdxW-1:0] idx_r, idx_nxt;
  logic                 valid_r, valid_nxt;
  out_item_t            item_r;
  out_item_t            item_nxt;
  logic                 load;
  logic                 at_end;

  assign load   = !stat.empty && (!valid_r || out_pop);
  assign at_end = (idx_r == cmd.last_idx);
  assign rd_en  = load && at_end;

  // Pick the next result out of the head burst
  always_comb begin
    item_nxt.payload_byte = cmd.bytes[idx_r];
    item_nxt.unit_first   = cmd.first && (idx_r == '0);
    item_nxt.unit_last    = cmd.last && at_end;
    item_nxt.unit_number  = cmd.unit_number;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_end ? '0 : idx_r + 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) item_r <= item_nxt;
  end

  assign out_empty = !valid_r;
  assign out_item  = item_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> idx_r <= cmd.last_idx)
    else $error("burst index past end of command");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> idx_r == '0)
    else $error("burst index left mid-command with empty queue");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_pop |=> valid_r && $stable(item_r))
    else $error("waiting result changed before pop");

endmodule

@@ sv/annexb_nal_unit_deframer_core.sv @@
`timescale 1ns / 1ps
// Annex B NAL unit deframer. Raw stream bytes go in through a push/full queue
// port, one per clock while in_full is low; payload bytes of each NAL unit
// come out of a pop/empty queue port with first/last marks and a wrapping
// 16-bit unit number. Start code search and the three-byte lookahead run in
// the front stage, which takes a byte every cycle while the 4-entry command
// queue has room. Each byte causes at most one result, except the end-of-stream
// byte inside a unit, which flushes up to four results; the back stage drains
// those at one result per cycle unless a waiting result has not been popped,
// and the front keeps accepting until the command queue fills.
module annexb_nal_unit_deframer_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  annexb_pkg::in_item_t  in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output annexb_pkg::out_item_t out_item
);
  import annexb_pkg::*;

  logic       accept;
  logic       wr_en;
  logic       rd_en;
  cmd_t       wr_cmd;
  cmd_t       rd_cmd;
  fifo_stat_t stat;

  assign in_full = stat.full;
  assign accept  = in_push && !stat.full;

  annexb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .wr_en   (wr_en),
    .cmd     (wr_cmd)
  );

  annexb_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_cmd (wr_cmd),
    .rd_en  (rd_en),
    .rd_cmd (rd_cmd),
    .stat   (stat)
  );

  annexb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rd_cmd),
    .stat      (stat),
    .rd_en     (rd_en),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
